// ===== hw/rtl/yrs_pkg.sv =====
// Shared types, register codes and defaults for the YUV color run segmenter.
// Depends on nothing; every other file of the block imports it.
package yrs_pkg;

  // Default line length limit; the column counter saturates one below it.
  localparam int MAX_WIDTH_DEF = 2048;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FILTER_MODE  = 3'd0,
    REG_RED_U_BELOW  = 3'd1,
    REG_RED_V_ABOVE  = 3'd2,
    REG_RED_V_OVER_U = 3'd3,
    REG_GREEN_MIN    = 3'd4,
    REG_GREEN_MARGIN = 3'd5
  } reg_idx_t;

  localparam int IDX_W  = 3;
  localparam int DATA_W = 8;

  // Filter mode codes.
  localparam logic MODE_RED   = 1'b0;
  localparam logic MODE_GREEN = 1'b1;

  // Register values after reset.
  localparam logic [7:0] RED_U_BELOW_RST  = 8'd120;
  localparam logic [7:0] RED_V_ABOVE_RST  = 8'd170;
  localparam logic [7:0] RED_V_OVER_U_RST = 8'd90;
  localparam logic [7:0] GREEN_MIN_RST    = 8'd70;
  localparam logic [7:0] GREEN_MARGIN_RST = 8'd20;

  // Input beat: one pixel.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       end_of_line;
  } pix_in_t;

  // Output beat: one classification and an optional closed run.
  typedef struct packed {
    logic        pixel_match;
    logic        segment_valid;
    logic [10:0] segment_start;
    logic [11:0] segment_width;
  } seg_out_t;

  // Register file contents.
  typedef struct packed {
    logic       filter_mode;
    logic [7:0] red_u_below;
    logic [7:0] red_v_above;
    logic [7:0] red_v_over_u;
    logic [7:0] green_min;
    logic [7:0] green_margin;
  } cfg_t;

  // Classifier result handed to the run tracker.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       red_match;
    logic       eol;
  } class_t;

endpackage

// ===== hw/rtl/yuv_color_run_segmenter_unit.sv =====
// Top level of the YUV color run segmenter: config registers, classifier, run tracker.
// Depends on yrs_pkg, yrs_cfg_regs, yrs_classifier and yrs_run_tracker.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_ready     in_data   (pix_in_t)
//   out       output     out_valid / out_ready   out_data  (seg_out_t)
//   config    input      write_en                write_index, write_data
//
// Takes one pixel per clock unless stalled; every beat gives exactly one result beat.
// Pipeline: input register, rescale stage, RGB stage, output register.
// The run state is updated in the output stage, so back-to-back pixels need no wait.
// Reset clears the pipeline valid bits and the line state and loads register defaults.
// A stalled output holds its beat; empty stages upstream keep taking pixels.
module yuv_color_run_segmenter_unit #(
  parameter int MAX_WIDTH = yrs_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  yrs_pkg::pix_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output yrs_pkg::seg_out_t          out_data,
  input  logic                       write_en,
  input  logic [yrs_pkg::IDX_W-1:0]  write_index,
  input  logic [yrs_pkg::DATA_W-1:0] write_data
);
  import yrs_pkg::*;

  cfg_t   cfg;
  logic   cls_valid;
  logic   cls_ready;
  class_t cls_data;

  // Register file.
  yrs_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .cfg         (cfg)
  );

  // Color classification pipeline.
  yrs_classifier u_class (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (cls_valid),
    .res_ready (cls_ready),
    .res_data  (cls_data)
  );

  // Run tracking and output register.
  yrs_run_tracker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_runs (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls_data  (cls_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/yrs_cfg_regs.sv =====
// Configuration register file of the run segmenter.
// Depends on yrs_pkg for register codes, reset values and the cfg_t struct.
module yrs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_en,
  input  logic [yrs_pkg::IDX_W-1:0]   write_index,
  input  logic [yrs_pkg::DATA_W-1:0]  write_data,
  output yrs_pkg::cfg_t               cfg
);
  import yrs_pkg::*;

  // Write decode; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode  <= MODE_RED;
      cfg.red_u_below  <= RED_U_BELOW_RST;
      cfg.red_v_above  <= RED_V_ABOVE_RST;
      cfg.red_v_over_u <= RED_V_OVER_U_RST;
      cfg.green_min    <= GREEN_MIN_RST;
      cfg.green_margin <= GREEN_MARGIN_RST;
    end else if (write_en) begin
      unique case (reg_idx_t'(write_index))
        REG_FILTER_MODE:  cfg.filter_mode  <= write_data[0];
        REG_RED_U_BELOW:  cfg.red_u_below  <= write_data;
        REG_RED_V_ABOVE:  cfg.red_v_above  <= write_data;
        REG_RED_V_OVER_U: cfg.red_v_over_u <= write_data;
        REG_GREEN_MIN:    cfg.green_min    <= write_data;
        REG_GREEN_MARGIN: cfg.green_margin <= write_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/yrs_classifier.sv =====
// Three-stage color classifier: input register, video-range rescale, RGB conversion.
// Depends on yrs_pkg for the pixel, config and classifier result structs.
module yrs_classifier (
  input  logic             clk,
  input  logic             rst,
  input  yrs_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  yrs_pkg::pix_in_t in_data,
  output logic             res_valid,
  input  logic             res_ready,
  output yrs_pkg::class_t  res_data
);
  import yrs_pkg::*;

  typedef struct packed {
    logic [7:0] c;
    logic [7:0] qu;
    logic [7:0] qv;
    logic       red_match;
    logic       eol;
  } scaled_t;

  // Exact floor(n / 255) for n below 255 * 256.
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = {1'b0, n} + {9'b0, n[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // Clamp floor(s / 256) to 0..255.
  function automatic logic [7:0] clamp_hi(input logic signed [19:0] s);
    logic [7:0] r;
    if (s[19]) begin
      r = 8'd0;
    end else if (|s[18:16]) begin
      r = 8'd255;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

  logic    v0, v1, v2;
  logic    en0, en1, en2;
  pix_in_t p0;
  scaled_t s1;
  class_t  s2;

  // Each stage may load when it is empty or its contents move on.
  assign en2      = !v2 || res_ready;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en0) v0 <= in_valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en0 && in_valid) p0 <= in_data;
  end

  // Rescale to video range and run the red test.
  logic [15:0] ny, nu, nv;
  logic [8:0]  u_plus;
  scaled_t     s1_next;

  always_comb begin
    ny = 16'(p0.luma * 8'd219);
    nu = 16'(p0.chroma_u * 8'd224);
    nv = 16'(p0.chroma_v * 8'd224);
    u_plus = {1'b0, p0.chroma_u} + {1'b0, cfg.red_v_over_u};
    s1_next.c  = div255(ny);
    s1_next.qu = div255(nu);
    s1_next.qv = div255(nv);
    s1_next.red_match = (p0.chroma_u < cfg.red_u_below && p0.chroma_v > cfg.red_v_above) ||
                        ({1'b0, p0.chroma_v} > u_plus);
    s1_next.eol = p0.end_of_line;
  end

  always_ff @(posedge clk) begin
    if (en1 && v0) s1 <= s1_next;
  end

  // BT.601 integer conversion to RGB with clamping.
  logic signed [19:0] c20, d20, e20, r_sum, g_sum, b_sum;
  class_t             s2_next;

  always_comb begin
    c20   = $signed({12'b0, s1.c});
    d20   = $signed({12'b0, s1.qu}) - 20'sd112;
    e20   = $signed({12'b0, s1.qv}) - 20'sd112;
    r_sum = 20'sd298 * c20 + 20'sd409 * e20 + 20'sd128;
    g_sum = 20'sd298 * c20 - 20'sd100 * d20 - 20'sd208 * e20 + 20'sd128;
    b_sum = 20'sd298 * c20 + 20'sd516 * d20 + 20'sd128;
    s2_next.red       = clamp_hi(r_sum);
    s2_next.green     = clamp_hi(g_sum);
    s2_next.blue      = clamp_hi(b_sum);
    s2_next.red_match = s1.red_match;
    s2_next.eol       = s1.eol;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) s2 <= s2_next;
  end

  assign res_valid = v2;
  assign res_data  = s2;

endmodule

// ===== hw/rtl/yrs_run_tracker.sv =====
// Green test, match select and run tracking along the line, with the output register.
// Depends on yrs_pkg for the config, classifier result and output structs.
module yrs_run_tracker #(
  parameter int MAX_WIDTH = yrs_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  yrs_pkg::cfg_t     cfg,
  input  logic              cls_valid,
  output logic              cls_ready,
  input  yrs_pkg::class_t   cls_data,
  output logic              out_valid,
  input  logic              out_ready,
  output yrs_pkg::seg_out_t out_data
);
  import yrs_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int SPAN_W = COL_W + 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

  logic             column_en;
  logic [COL_W-1:0] column, column_next;
  logic             in_run, in_run_next;
  logic [COL_W-1:0] run_begin, run_begin_next;
  logic             accept;
  logic             green_match, match;
  logic [8:0]       r_plus, b_plus;
  logic [COL_W-1:0] begin_eff;
  logic [SPAN_W-1:0] span;
  seg_out_t         out_next;

  assign cls_ready = !out_valid || out_ready;
  assign accept    = cls_valid && cls_ready;
  assign column_en = accept;

  // Select the color test and work out the run update.
  always_comb begin
    r_plus = {1'b0, cls_data.red} + {1'b0, cfg.green_margin};
    b_plus = {1'b0, cls_data.blue} + {1'b0, cfg.green_margin};
    green_match = (cls_data.green >= cfg.green_min) &&
                  ({1'b0, cls_data.green} >= r_plus) &&
                  ({1'b0, cls_data.green} >= b_plus);
    match = (cfg.filter_mode == MODE_GREEN) ? green_match : cls_data.red_match;

    begin_eff = in_run ? run_begin : column;
    span = {1'b0, column} - {1'b0, begin_eff};

    out_next.pixel_match   = match;
    out_next.segment_valid = 1'b0;
    out_next.segment_start = '0;
    out_next.segment_width = '0;
    in_run_next    = in_run;
    run_begin_next = begin_eff;

    if (match) begin
      in_run_next = 1'b1;
      if (cls_data.eol) begin
        // A run still open at the end of the line includes this pixel.
        out_next.segment_valid = 1'b1;
        out_next.segment_start = 11'(begin_eff);
        out_next.segment_width = 12'(span + SPAN_W'(1));
      end
    end else if (in_run) begin
      // The non-matching pixel ends the run and is not part of it.
      out_next.segment_valid = 1'b1;
      out_next.segment_start = 11'(run_begin);
      out_next.segment_width = 12'(span);
      in_run_next = 1'b0;
    end

    // Column advances and saturates; the end of the line restarts it.
    if (cls_data.eol) begin
      column_next = '0;
      in_run_next = 1'b0;
    end else if (column != COL_LAST) begin
      column_next = column + COL_W'(1);
    end else begin
      column_next = column;
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      in_run    <= 1'b0;
      run_begin <= '0;
    end else if (column_en) begin
      column    <= column_next;
      in_run    <= in_run_next;
      run_begin <= run_begin_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data <= out_next;
  end

  // An end-of-line beat leaves the line state cleared.
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    accept && cls_data.eol |=> column == '0 && !in_run)
    else $error("line state not cleared after end of line");

  // An open run never starts to the right of the current column.
  a_begin_order: assert property (@(posedge clk) disable iff (rst)
    in_run |-> run_begin <= column)
    else $error("run start beyond current column");

  // A run reported as closed was open or ends at this end-of-line pixel.
  a_close_cause: assert property (@(posedge clk) disable iff (rst)
    accept && out_next.segment_valid |-> in_run || (match && cls_data.eol))
    else $error("segment reported without an open run");

  // A non-matching pixel closes an open run and reports it as a segment.
  a_close_state: assert property (@(posedge clk) disable iff (rst)
    accept && in_run && !match |=> !in_run && out_data.segment_valid)
    else $error("run not closed by a non-matching pixel");

endmodule

// ===== tb/tb_yuv_color_run_segmenter_unit.sv =====
// Self-checking testbench for the YUV color run segmenter: pixel and segment beats,
// register writes, and an independent model of the color tests and run tracking.
// Depends on yrs_pkg and yuv_color_run_segmenter_unit.
module tb_yuv_color_run_segmenter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import yrs_pkg::*;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_PIXELS = 190;

  localparam cfg_t DEFAULT_CFG = '{
    filter_mode:  MODE_RED,
    red_u_below:  RED_U_BELOW_RST,
    red_v_above:  RED_V_ABOVE_RST,
    red_v_over_u: RED_V_OVER_U_RST,
    green_min:    GREEN_MIN_RST,
    green_margin: GREEN_MARGIN_RST
  };

  // Model of the block: register copy, line state and the segment beats still owed.
  class segment_predictor;
    cfg_t     regs;
    int       column;
    bit       in_run;
    int       run_begin;
    seg_out_t owed_q[$];
    int       mismatch_count;
    int       segments_checked;
    int       runs_closed;

    function new();
      regs = DEFAULT_CFG;
      column = 0;
      in_run = 0;
      run_begin = 0;
      mismatch_count = 0;
      segments_checked = 0;
      runs_closed = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_FILTER_MODE:  regs.filter_mode = data[0];
        REG_RED_U_BELOW:  regs.red_u_below = data;
        REG_RED_V_ABOVE:  regs.red_v_above = data;
        REG_RED_V_OVER_U: regs.red_v_over_u = data;
        REG_GREEN_MIN:    regs.green_min = data;
        REG_GREEN_MARGIN: regs.green_margin = data;
        default: ;
      endcase
    endfunction

    static function int to_byte(int x);
      return (x < 0) ? 0 : ((x > 255) ? 255 : x);
    endfunction

    // Red works on raw U and V; green rescales to video range and converts to RGB.
    function bit is_target(pix_in_t px);
      int ys, us, vs, c, d, e, r, g, b;
      if (regs.filter_mode == MODE_RED) begin
        return (int'(px.chroma_u) < int'(regs.red_u_below) &&
                int'(px.chroma_v) > int'(regs.red_v_above)) ||
               (int'(px.chroma_v) > int'(px.chroma_u) + int'(regs.red_v_over_u));
      end
      ys = 16 + (int'(px.luma) * 219) / 255;
      us = 16 + (int'(px.chroma_u) * 224) / 255;
      vs = 16 + (int'(px.chroma_v) * 224) / 255;
      c = ys - 16;
      d = us - 128;
      e = vs - 128;
      // Arithmetic shift of a signed value rounds toward minus infinity.
      r = to_byte((298 * c + 409 * e + 128) >>> 8);
      g = to_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
      b = to_byte((298 * c + 516 * d + 128) >>> 8);
      return g >= int'(regs.green_min) &&
             g >= r + int'(regs.green_margin) &&
             g >= b + int'(regs.green_margin);
    endfunction

    // Every accepted pixel owes exactly one segment beat.
    function void note_pixel(pix_in_t px);
      seg_out_t seg;
      bit hit;
      hit = is_target(px);
      seg = '0;
      seg.pixel_match = hit;
      if (hit) begin
        if (!in_run) begin
          in_run = 1;
          run_begin = column;
        end
        // A run still open at the end of the line closes with this pixel in it.
        if (px.end_of_line) begin
          seg.segment_valid = 1'b1;
          seg.segment_start = 11'(run_begin);
          seg.segment_width = 12'(column - run_begin + 1);
        end
      end else if (in_run) begin
        seg.segment_valid = 1'b1;
        seg.segment_start = 11'(run_begin);
        seg.segment_width = 12'(column - run_begin);
        in_run = 0;
      end
      // The column sticks at the last position on lines that are too long.
      if (px.end_of_line) begin
        column = 0;
        in_run = 0;
      end else if (column < MAX_WIDTH_DEF - 1) begin
        column++;
      end
      owed_q.insert(owed_q.size(), seg);
    endfunction

    task flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 40) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
    endtask

    task compare_field(string name, logic [11:0] got, logic [11:0] want);
      if (got !== want) begin
        flag_mismatch($sformatf("segment beat %0d: %s is %0h, should be %0h",
                                segments_checked, name, got, want));
      end
    endtask

    task check_segment(seg_out_t got);
      seg_out_t want;
      if (owed_q.size() == 0) begin
        flag_mismatch($sformatf("segment beat with nothing owed: %p", got));
        return;
      end
      want = owed_q.pop_front();
      compare_field("pixel_match", 12'(got.pixel_match), 12'(want.pixel_match));
      compare_field("segment_valid", 12'(got.segment_valid), 12'(want.segment_valid));
      compare_field("segment_start", 12'(got.segment_start), 12'(want.segment_start));
      compare_field("segment_width", got.segment_width, want.segment_width);
      if (want.segment_valid) begin
        runs_closed++;
      end
      segments_checked++;
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  pix_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  seg_out_t               out_data;
  logic                   write_en = 1'b0;
  logic [IDX_W-1:0]       write_index = '0;
  logic [DATA_W-1:0]      write_data = '0;

  segment_predictor seg_model = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int pixels_sent = 0;
  int settings_applied = 0;

  yuv_color_run_segmenter_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data)
  );

  always #2 clk = ~clk;

  function automatic pix_in_t pix(logic [7:0] y, logic [7:0] u, logic [7:0] v, logic eol);
    pix_in_t px;
    px.luma = y;
    px.chroma_u = u;
    px.chroma_v = v;
    px.end_of_line = eol;
    return px;
  endfunction

  // Offers one pixel beat after a random gap and returns at the edge that takes it.
  task automatic send_pixel(input pix_in_t px);
    int gap;
    if (pixels_sent % 40 == 0) begin
      idle_on = ($urandom_range(0, 2) != 0);
    end
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    seg_model.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    seg_model.write_reg(idx, data);
  endtask

  // Writes every register back to back, plus the unused indexes.
  task automatic apply_setting(input cfg_t s);
    put_reg(REG_FILTER_MODE, {7'($urandom), s.filter_mode});
    put_reg(REG_RED_U_BELOW, s.red_u_below);
    put_reg(REG_RED_V_ABOVE, s.red_v_above);
    put_reg(REG_RED_V_OVER_U, s.red_v_over_u);
    put_reg(REG_GREEN_MIN, s.green_min);
    put_reg(REG_GREEN_MARGIN, s.green_margin);
    put_reg(IDX_SPARE_A, 8'($urandom));
    put_reg(IDX_SPARE_B, 8'($urandom));
    write_en <= 1'b0;
    settings_applied++;
  endtask

  // Stops offering and waits until every owed beat is back and the pipeline is empty.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (seg_model.owed_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Output side: random stalls per beat, plus one long hold-off on request.
  initial begin : segment_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        seg_model.check_segment(out_data);
        stall_left = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    cfg_t    s;
    pix_in_t px;
    bit      want_hit;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Red test at reset thresholds: boundaries, runs closed both ways, short lines.
    send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd255, 8'd0, 8'd255, 1'b0));
    send_pixel(pix(8'd17, 8'd0, 8'd255, 1'b0));
    send_pixel(pix(8'd128, 8'd128, 8'd128, 1'b0));
    send_pixel(pix(8'd3, 8'd0, 8'd255, 1'b1));
    send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(pix(8'd40, 8'd100, 8'd191, 1'b0));
    send_pixel(pix(8'd40, 8'd120, 8'd171, 1'b0));
    send_pixel(pix(8'd40, 8'd119, 8'd171, 1'b0));
    send_pixel(pix(8'd40, 8'd119, 8'd170, 1'b0));
    send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b1));
    send_pixel(pix(8'd90, 8'd10, 8'd250, 1'b1));
    send_pixel(pix(8'd90, 8'd10, 8'd250, 1'b0));
    send_pixel(pix(8'd90, 8'd10, 8'd250, 1'b1));

    // Green test at reset thresholds, including the clamped corners.
    wait_drain();
    s = DEFAULT_CFG;
    s.filter_mode = MODE_GREEN;
    apply_setting(s);
    send_pixel(pix(8'd255, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(pix(8'd0, 8'd255, 8'd255, 1'b0));
    send_pixel(pix(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(pix(8'd200, 8'd40, 8'd40, 1'b0));
    send_pixel(pix(8'd200, 8'd40, 8'd40, 1'b1));
    send_pixel(pix(8'd0, 8'd0, 8'd0, 1'b1));

    // Random lines under a mix of extreme and random register settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drain();
      s.red_u_below = 8'($urandom);
      s.red_v_above = 8'($urandom);
      s.red_v_over_u = 8'($urandom);
      s.green_min = 8'($urandom);
      s.green_margin = 8'($urandom);
      case (p)
        0: begin
          s.filter_mode = MODE_RED;
          s.red_u_below = 8'd255;
          s.red_v_above = 8'd0;
          s.red_v_over_u = 8'd0;
        end
        1: begin
          s.filter_mode = MODE_GREEN;
          s.green_min = 8'd0;
          s.green_margin = 8'd0;
        end
        2: s.filter_mode = MODE_RED;
        3: begin
          s.filter_mode = MODE_GREEN;
          s.green_min = 8'd255;
          s.green_margin = 8'd255;
        end
        4: s.filter_mode = MODE_GREEN;
        default: begin
          s.filter_mode = MODE_RED;
          s.red_u_below = 8'd0;
          s.red_v_above = 8'd255;
          s.red_v_over_u = 8'd255;
        end
      endcase
      apply_setting(s);
      // Fill the pipeline against a stalled output once.
      if (p == 2) begin
        hold_req = 1'b1;
      end
      want_hit = 1'b0;
      repeat (PHASE_PIXELS) begin
        if ($urandom_range(0, 3) == 0) begin
          want_hit = !want_hit;
        end
        px = 25'($urandom);
        // Bias toward the target color so that runs of useful length form.
        if (want_hit) begin
          if (s.filter_mode == MODE_GREEN) begin
            px.luma = 8'($urandom_range(110, 255));
            px.chroma_u = 8'($urandom_range(0, 90));
            px.chroma_v = 8'($urandom_range(0, 90));
          end else begin
            px.chroma_u = 8'($urandom_range(0, 110));
            px.chroma_v = 8'($urandom_range(200, 255));
          end
        end
        px.end_of_line = ($urandom_range(0, 11) == 0);
        send_pixel(px);
      end
    end

    wait_drain();
    repeat (16) @(posedge clk);
    $display("Summary: %0d pixels under %0d register settings, %0d beats checked, %0d runs.",
             pixels_sent, settings_applied + 1, seg_model.segments_checked,
             seg_model.runs_closed);
    $display("Summary: one %0d-cycle output hold-off and %0d random line phases.",
             HOLD_CYCLES, RANDOM_PHASES);
    if (seg_model.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #2_000_000ns;
    $display("Timeout with %0d beats still owed.", seg_model.owed_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/yrs_pkg.sv
hw/rtl/yrs_cfg_regs.sv
hw/rtl/yrs_classifier.sv
hw/rtl/yrs_run_tracker.sv
hw/rtl/yuv_color_run_segmenter_unit.sv
tb/tb_yuv_color_run_segmenter_unit.sv
